FILE: sv/tid_pkg.sv
`default_nettype none

package tid_pkg;

    // Operation classes, dense 5-bit code
    typedef enum logic [4:0] {
        OP_MOV    = 5'd0,
        OP_ADD    = 5'd1,
        OP_SUB    = 5'd2,
        OP_CMP    = 5'd3,
        OP_AND    = 5'd4,
        OP_EOR    = 5'd5,
        OP_ADC    = 5'd6,
        OP_SBC    = 5'd7,
        OP_TST    = 5'd8,
        OP_RSB    = 5'd9,
        OP_CMN    = 5'd10,
        OP_ORR    = 5'd11,
        OP_MUL    = 5'd12,
        OP_BIC    = 5'd13,
        OP_MVN    = 5'd14,
        OP_BX     = 5'd15,
        OP_BLXR   = 5'd16,
        OP_LDR    = 5'd17,
        OP_LDRB   = 5'd18,
        OP_STR    = 5'd19,
        OP_STRB   = 5'd20,
        OP_STRH   = 5'd21,
        OP_LDRH   = 5'd22,
        OP_LDRSB  = 5'd23,
        OP_LDRSH  = 5'd24,
        OP_LDM    = 5'd25,
        OP_STM    = 5'd26,
        OP_B      = 5'd27,
        OP_SWI    = 5'd28,
        OP_BLPRE  = 5'd29,
        OP_BLSUF  = 5'd30,
        OP_UNDEF  = 5'd31
    } op_t;

    // Condition codes
    localparam logic [3:0] COND_AL = 4'd14;

    // Special register numbers
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    // Operand kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_IMM     = 2'd1;
    localparam logic [1:0] KIND_REG_IMM = 2'd2;
    localparam logic [1:0] KIND_REG_REG = 2'd3;

    // Shift types
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // Control flag bits
    localparam logic [8:0] CF_SET  = 9'h001;
    localparam logic [8:0] CF_BR   = 9'h002;
    localparam logic [8:0] CF_IND  = 9'h004;
    localparam logic [8:0] CF_CALL = 9'h008;
    localparam logic [8:0] CF_RET  = 9'h010;
    localparam logic [8:0] CF_PCW  = 9'h020;
    localparam logic [8:0] CF_LINK = 9'h040;
    localparam logic [8:0] CF_XCH  = 9'h080;
    localparam logic [8:0] CF_UND  = 9'h100;

    // Addressing flag bits
    localparam logic [5:0] AF_PRE  = 6'h01;
    localparam logic [5:0] AF_ADD  = 6'h02;
    localparam logic [5:0] AF_WB   = 6'h04;
    localparam logic [5:0] AF_BYTE = 6'h08;
    localparam logic [5:0] AF_ROFF = 6'h10;
    localparam logic [5:0] AF_LOAD = 6'h20;

    // Decoded micro-operation record
    typedef struct packed {
        op_t         op_class;
        logic [3:0]  cond;
        logic [3:0]  dest_reg;
        logic [3:0]  base_reg;
        logic [3:0]  second_reg;
        logic [1:0]  operand_kind;
        logic [1:0]  shift_type;
        logic [4:0]  shift_amount;
        logic [31:0] value;
        logic [8:0]  control_flags;
        logic [5:0]  address_flags;
    } uop_t;

endpackage

`default_nettype wire

FILE: sv/tid_if.sv
`default_nettype none

// Instruction fetch channel: one halfword and its address per transfer
interface tid_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] halfword;
    logic [31:0] fetch_address;

    modport source (output valid, output halfword, output fetch_address, input ready);
    modport sink   (input valid, input halfword, input fetch_address, output ready);
endinterface

// Micro-operation channel: one decoded record per transfer
interface tid_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  op_class;
    logic [3:0]  cond;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic [3:0]  second_reg;
    logic [1:0]  operand_kind;
    logic [1:0]  shift_type;
    logic [4:0]  shift_amount;
    logic [31:0] value;
    logic [8:0]  control_flags;
    logic [5:0]  address_flags;

    modport source (
        output valid, output op_class, output cond, output dest_reg, output base_reg,
        output second_reg, output operand_kind, output shift_type, output shift_amount,
        output value, output control_flags, output address_flags, input ready
    );
    modport sink (
        input valid, input op_class, input cond, input dest_reg, input base_reg,
        input second_reg, input operand_kind, input shift_type, input shift_amount,
        input value, input control_flags, input address_flags, output ready
    );
endinterface

`default_nettype wire

FILE: sv/thumb_instruction_decoder_core.sv
// Channel  | Dir | Payload                                      | Handshake
// ---------+-----+----------------------------------------------+-------------
// instr    | in  | halfword[15:0], fetch_address[31:0]          | valid/ready
// uop      | out | op_class .. address_flags (decoded record)   | valid/ready
//
// One halfword per cycle sustained while the uop channel accepts; an accepted
// halfword passes through the input register, decode logic and result
// register, in that order.
// rst_n clears both stage valid bits asynchronously; payload is not reset.
// A stalled uop channel holds the result register; the input register still
// drains into it when it empties, so instr.ready only drops with both full.
// instr.ready depends combinationally on uop.ready.
`default_nettype none

module thumb_instruction_decoder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tid_in_if.sink     instr,
    tid_out_if.source  uop
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [15:0]   halfword_reg;
    logic [31:0]   fetch_address_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    tid_pkg::uop_t uop_reg;
    tid_pkg::uop_t uop_dec;
    logic          out_advance;
    logic          in_advance;

    // Stage handshakes
    assign out_advance = !out_valid_reg || uop.ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign instr.ready = in_advance;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_advance)
        begin
            in_valid_next = instr.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && instr.valid)
        begin
            halfword_reg      <= instr.halfword;
            fetch_address_reg <= instr.fetch_address;
        end
    end

    // Decode logic
    tid_decode u_decode (
        .halfword      (halfword_reg),
        .fetch_address (fetch_address_reg),
        .uop           (uop_dec)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            uop_reg <= uop_dec;
        end
    end

    // Output channel
    assign uop.valid         = out_valid_reg;
    assign uop.op_class      = uop_reg.op_class;
    assign uop.cond          = uop_reg.cond;
    assign uop.dest_reg      = uop_reg.dest_reg;
    assign uop.base_reg      = uop_reg.base_reg;
    assign uop.second_reg    = uop_reg.second_reg;
    assign uop.operand_kind  = uop_reg.operand_kind;
    assign uop.shift_type    = uop_reg.shift_type;
    assign uop.shift_amount  = uop_reg.shift_amount;
    assign uop.value         = uop_reg.value;
    assign uop.control_flags = uop_reg.control_flags;
    assign uop.address_flags = uop_reg.address_flags;

    // Backpressure only when both stages hold an item
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !instr.ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // A decoded item moves into a free or draining result register
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("decoded item lost between stages");

    // Undefined flag goes with the undefined class only
    a_undef: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (uop_reg.control_flags[8] == (uop_reg.op_class == tid_pkg::OP_UNDEF)))
        else $error("undefined flag and class disagree");

    // Only a conditional branch carries a condition other than always
    a_cond: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && uop_reg.cond != tid_pkg::COND_AL)
            |-> (uop_reg.op_class == tid_pkg::OP_B))
        else $error("condition on a non-branch");

endmodule

`default_nettype wire

FILE: sv/tid_decode.sv
`default_nettype none

// Combinational THUMB decoder: one halfword in, one micro-op record out
module tid_decode (
    input  wire logic [15:0]   halfword,
    input  wire logic [31:0]   fetch_address,
    output tid_pkg::uop_t      uop
);

    logic [2:0]  top3;
    logic [2:0]  lo3;
    logic [2:0]  mid3;
    logic [3:0]  alu_sel;
    logic [3:0]  hi_rd;
    logic [3:0]  hi_rs;
    logic [31:0] br_offset;
    logic [31:0] br_target;
    tid_pkg::uop_t d;

    assign top3    = halfword[15:13];
    assign lo3     = halfword[2:0];
    assign mid3    = halfword[5:3];
    assign alu_sel = halfword[9:6];
    assign hi_rd   = {halfword[7], lo3};
    assign hi_rs   = {halfword[6], mid3};

    // Branch offset select: conditional, unconditional, or BL prefix
    always_comb
    begin
        if (top3 == 3'd6)
        begin
            br_offset = {{23{halfword[7]}}, halfword[7:0], 1'b0};
        end
        else if (halfword[12:11] == 2'd2)
        begin
            br_offset = {{9{halfword[10]}}, halfword[10:0], 12'd0};
        end
        else
        begin
            br_offset = {{20{halfword[10]}}, halfword[10:0], 1'b0};
        end
    end

    // Pipeline PC is fetch address plus 4, wraps modulo 2^32
    assign br_target = fetch_address + 32'd4 + br_offset;

    // Format decode
    always_comb
    begin
        d               = '0;
        d.op_class      = tid_pkg::OP_MOV;
        d.cond          = tid_pkg::COND_AL;

        unique case (top3)
            3'd0:
            begin
                d.control_flags = tid_pkg::CF_SET;
                d.dest_reg      = {1'b0, lo3};
                if (halfword[12:11] == 2'd3)
                begin
                    // add/subtract, register or 3-bit immediate
                    d.op_class = halfword[9] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
                    d.base_reg = {1'b0, mid3};
                    if (halfword[10])
                    begin
                        d.operand_kind = tid_pkg::KIND_IMM;
                        d.value        = {29'd0, halfword[8:6]};
                    end
                    else
                    begin
                        d.operand_kind = tid_pkg::KIND_REG_IMM;
                        d.second_reg   = {1'b0, halfword[8:6]};
                    end
                end
                else
                begin
                    // move shifted register
                    d.op_class     = tid_pkg::OP_MOV;
                    d.second_reg   = {1'b0, mid3};
                    d.operand_kind = tid_pkg::KIND_REG_IMM;
                    d.shift_type   = halfword[12:11];
                    d.shift_amount = halfword[10:6];
                end
            end

            3'd1:
            begin
                // move/compare/add/subtract immediate
                unique case (halfword[12:11])
                    2'd0:    d.op_class = tid_pkg::OP_MOV;
                    2'd1:    d.op_class = tid_pkg::OP_CMP;
                    2'd2:    d.op_class = tid_pkg::OP_ADD;
                    default: d.op_class = tid_pkg::OP_SUB;
                endcase
                d.control_flags = tid_pkg::CF_SET;
                d.dest_reg      = {1'b0, halfword[10:8]};
                d.base_reg      = {1'b0, halfword[10:8]};
                d.operand_kind  = tid_pkg::KIND_IMM;
                d.value         = {24'd0, halfword[7:0]};
            end

            3'd2:
            begin
                if (halfword[12:10] == 3'd0)
                begin
                    // ALU register-register
                    d.control_flags = tid_pkg::CF_SET;
                    d.dest_reg      = {1'b0, lo3};
                    d.base_reg      = {1'b0, lo3};
                    d.operand_kind  = tid_pkg::KIND_REG_IMM;
                    d.second_reg    = {1'b0, mid3};
                    unique case (alu_sel) inside
                        4'd0:  d.op_class = tid_pkg::OP_AND;
                        4'd1:  d.op_class = tid_pkg::OP_EOR;
                        4'd2, 4'd3, 4'd4, 4'd7:
                        begin
                            d.op_class     = tid_pkg::OP_MOV;
                            d.operand_kind = tid_pkg::KIND_REG_REG;
                            d.second_reg   = {1'b0, lo3};
                            d.shift_amount = {2'b00, mid3};
                            unique case (alu_sel)
                                4'd2:    d.shift_type = tid_pkg::SHIFT_LSL;
                                4'd3:    d.shift_type = tid_pkg::SHIFT_LSR;
                                4'd4:    d.shift_type = tid_pkg::SHIFT_ASR;
                                default: d.shift_type = tid_pkg::SHIFT_ROR;
                            endcase
                        end
                        4'd5:  d.op_class = tid_pkg::OP_ADC;
                        4'd6:  d.op_class = tid_pkg::OP_SBC;
                        4'd8:  d.op_class = tid_pkg::OP_TST;
                        4'd9:
                        begin
                            // NEG: RSB Rd, Rs, #0
                            d.op_class     = tid_pkg::OP_RSB;
                            d.base_reg     = {1'b0, mid3};
                            d.operand_kind = tid_pkg::KIND_IMM;
                            d.second_reg   = '0;
                        end
                        4'd10: d.op_class = tid_pkg::OP_CMP;
                        4'd11: d.op_class = tid_pkg::OP_CMN;
                        4'd12: d.op_class = tid_pkg::OP_ORR;
                        4'd13:
                        begin
                            // multiplier register travels in the shift amount
                            d.op_class     = tid_pkg::OP_MUL;
                            d.operand_kind = tid_pkg::KIND_NONE;
                            d.second_reg   = {1'b0, lo3};
                            d.shift_amount = {2'b00, mid3};
                        end
                        4'd14: d.op_class = tid_pkg::OP_BIC;
                        default: d.op_class = tid_pkg::OP_MVN;
                    endcase
                end
                else if (halfword[12:10] == 3'd1)
                begin
                    // hi-register operations and BX/BLX
                    if (halfword[9:8] == 2'd3)
                    begin
                        d.op_class      = halfword[7] ? tid_pkg::OP_BLXR : tid_pkg::OP_BX;
                        d.second_reg    = hi_rs;
                        d.control_flags = tid_pkg::CF_XCH | tid_pkg::CF_BR | tid_pkg::CF_IND;
                        if (halfword[7])
                        begin
                            d.control_flags = d.control_flags | tid_pkg::CF_LINK
                                            | tid_pkg::CF_CALL;
                        end
                        else if (hi_rs == tid_pkg::REG_LR)
                        begin
                            d.control_flags = d.control_flags | tid_pkg::CF_RET;
                        end
                    end
                    else
                    begin
                        unique case (halfword[9:8])
                            2'd0:    d.op_class = tid_pkg::OP_ADD;
                            2'd1:    d.op_class = tid_pkg::OP_CMP;
                            default: d.op_class = tid_pkg::OP_MOV;
                        endcase
                        if (halfword[9:8] == 2'd1)
                        begin
                            d.control_flags = tid_pkg::CF_SET;
                        end
                        d.dest_reg     = hi_rd;
                        d.base_reg     = hi_rd;
                        d.operand_kind = tid_pkg::KIND_REG_IMM;
                        d.second_reg   = hi_rs;
                        if (hi_rd == tid_pkg::REG_PC && halfword[9:8] != 2'd1)
                        begin
                            d.control_flags = d.control_flags | tid_pkg::CF_PCW
                                            | tid_pkg::CF_BR | tid_pkg::CF_IND;
                        end
                    end
                end
                else if (halfword[12:11] == 2'd1)
                begin
                    // PC-relative load
                    d.op_class      = tid_pkg::OP_LDR;
                    d.dest_reg      = {1'b0, halfword[10:8]};
                    d.base_reg      = tid_pkg::REG_PC;
                    d.value         = {22'd0, halfword[7:0], 2'b00};
                    d.address_flags = tid_pkg::AF_PRE | tid_pkg::AF_ADD;
                end
                else
                begin
                    // load/store with register offset
                    d.dest_reg      = {1'b0, lo3};
                    d.base_reg      = {1'b0, mid3};
                    d.second_reg    = {1'b0, halfword[8:6]};
                    d.address_flags = tid_pkg::AF_PRE | tid_pkg::AF_ADD | tid_pkg::AF_ROFF;
                    unique case ({halfword[9], halfword[11], halfword[10]})
                        3'b100:  d.op_class = tid_pkg::OP_STRH;
                        3'b101:  d.op_class = tid_pkg::OP_LDRSB;
                        3'b110:  d.op_class = tid_pkg::OP_LDRH;
                        3'b111:  d.op_class = tid_pkg::OP_LDRSH;
                        3'b000:  d.op_class = tid_pkg::OP_STR;
                        3'b001:  d.op_class = tid_pkg::OP_STRB;
                        3'b010:  d.op_class = tid_pkg::OP_LDR;
                        default: d.op_class = tid_pkg::OP_LDRB;
                    endcase
                    if (!halfword[9] && halfword[10])
                    begin
                        d.address_flags = d.address_flags | tid_pkg::AF_BYTE;
                    end
                end
            end

            3'd3:
            begin
                // load/store with 5-bit immediate offset
                unique case (halfword[12:11])
                    2'd0:    d.op_class = tid_pkg::OP_STR;
                    2'd1:    d.op_class = tid_pkg::OP_LDR;
                    2'd2:    d.op_class = tid_pkg::OP_STRB;
                    default: d.op_class = tid_pkg::OP_LDRB;
                endcase
                d.dest_reg      = {1'b0, lo3};
                d.base_reg      = {1'b0, mid3};
                d.value         = halfword[12] ? {27'd0, halfword[10:6]}
                                               : {25'd0, halfword[10:6], 2'b00};
                d.address_flags = tid_pkg::AF_PRE | tid_pkg::AF_ADD;
            end

            3'd4:
            begin
                d.address_flags = tid_pkg::AF_PRE | tid_pkg::AF_ADD;
                if (!halfword[12])
                begin
                    // halfword transfer, immediate offset
                    d.op_class = halfword[11] ? tid_pkg::OP_LDRH : tid_pkg::OP_STRH;
                    d.dest_reg = {1'b0, lo3};
                    d.base_reg = {1'b0, mid3};
                    d.value    = {26'd0, halfword[10:6], 1'b0};
                end
                else
                begin
                    // SP-relative transfer
                    d.op_class = halfword[11] ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
                    d.dest_reg = {1'b0, halfword[10:8]};
                    d.base_reg = tid_pkg::REG_SP;
                    d.value    = {22'd0, halfword[7:0], 2'b00};
                end
            end

            3'd5:
            begin
                if (!halfword[12])
                begin
                    // load address from PC or SP
                    d.op_class     = tid_pkg::OP_ADD;
                    d.dest_reg     = {1'b0, halfword[10:8]};
                    d.base_reg     = halfword[11] ? tid_pkg::REG_SP : tid_pkg::REG_PC;
                    d.operand_kind = tid_pkg::KIND_IMM;
                    d.value        = {22'd0, halfword[7:0], 2'b00};
                end
                else if (halfword[10:9] == 2'b10)
                begin
                    // PUSH / POP, optional LR or PC
                    d.op_class = halfword[11] ? tid_pkg::OP_LDM : tid_pkg::OP_STM;
                    d.base_reg = tid_pkg::REG_SP;
                    d.value    = {16'd0, halfword[8] & halfword[11],
                                  halfword[8] & ~halfword[11], 6'd0, halfword[7:0]};
                    if (halfword[11])
                    begin
                        d.address_flags = tid_pkg::AF_WB | tid_pkg::AF_ADD | tid_pkg::AF_LOAD;
                    end
                    else
                    begin
                        d.address_flags = tid_pkg::AF_WB | tid_pkg::AF_PRE;
                    end
                    if (halfword[11] && halfword[8])
                    begin
                        d.control_flags = tid_pkg::CF_PCW | tid_pkg::CF_BR
                                        | tid_pkg::CF_IND | tid_pkg::CF_RET;
                    end
                end
                else if (halfword[11:8] == 4'd0)
                begin
                    // adjust SP by 7-bit word offset, sign in bit 7 (sign-magnitude)
                    d.op_class     = halfword[7] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
                    d.dest_reg     = tid_pkg::REG_SP;
                    d.base_reg     = tid_pkg::REG_SP;
                    d.operand_kind = tid_pkg::KIND_IMM;
                    d.value        = {23'd0, halfword[6:0], 2'b00};
                end
                else
                begin
                    d.op_class      = tid_pkg::OP_UNDEF;
                    d.control_flags = tid_pkg::CF_UND;
                end
            end

            3'd6:
            begin
                if (!halfword[12])
                begin
                    // multiple load/store
                    d.op_class      = halfword[11] ? tid_pkg::OP_LDM : tid_pkg::OP_STM;
                    d.base_reg      = {1'b0, halfword[10:8]};
                    d.value         = {24'd0, halfword[7:0]};
                    d.address_flags = tid_pkg::AF_ADD | tid_pkg::AF_WB
                                    | (halfword[11] ? tid_pkg::AF_LOAD : 6'd0);
                end
                else if (halfword[11:8] == 4'hF)
                begin
                    d.op_class = tid_pkg::OP_SWI;
                    d.value    = {24'd0, halfword[7:0]};
                end
                else
                begin
                    // conditional branch, condition field passes through
                    d.op_class      = tid_pkg::OP_B;
                    d.cond          = halfword[11:8];
                    d.control_flags = tid_pkg::CF_BR;
                    d.value         = br_target;
                end
            end

            default:
            begin
                if (halfword[12:11] == 2'd0)
                begin
                    d.op_class      = tid_pkg::OP_B;
                    d.control_flags = tid_pkg::CF_BR;
                    d.value         = br_target;
                end
                else
                begin
                    d.control_flags = tid_pkg::CF_LINK | tid_pkg::CF_BR | tid_pkg::CF_CALL;
                    if (halfword[12:11] == 2'd2)
                    begin
                        d.op_class = tid_pkg::OP_BLPRE;
                        d.value    = br_target;
                    end
                    else
                    begin
                        d.op_class = tid_pkg::OP_BLSUF;
                        d.value    = {20'd0, halfword[10:0], 1'b0};
                        if (halfword[12:11] == 2'd1)
                        begin
                            d.control_flags = d.control_flags | tid_pkg::CF_XCH;
                        end
                    end
                end
            end
        endcase
    end

    assign uop = d;

endmodule

`default_nettype wire
